// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define CHK_ASSERT(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("port check failed");

// Clocked check that also runs through reset.
`define CHK_ASSERT_NR(label, clk_s, prop) \
  label: assert property (@(posedge clk_s) prop) \
    else $error("port check failed");

`endif

// ===== hdl/lhrm_pkg.sv =====
// ---------------------------------------------------------------------------
// lhrm_pkg
// Types and constants of the loop hit recorder merge unit.
// ---------------------------------------------------------------------------
package lhrm_pkg;

  localparam int LOOP_DEPTH = 128;
  localparam int NEW_DEPTH  = 64;
  localparam int POS_BITS   = 16;

  localparam int LOOP_AW = $clog2(LOOP_DEPTH);
  localparam int NEW_AW  = $clog2(NEW_DEPTH);
  localparam int LEN_W   = $clog2(LOOP_DEPTH + 1);
  localparam int NLEN_W  = $clog2(NEW_DEPTH + 1);
  localparam int TOT_W   = $clog2(LOOP_DEPTH + NEW_DEPTH + 1);

  // fixed field widths
  localparam int REQ_W   = 3;
  localparam int PTR_W   = 7;
  localparam int MAXN_W  = 7;
  localparam int MAXL_W  = 8;
  localparam int CNT_W   = 8;
  localparam int NCNT_W  = 7;
  localparam int CFG_AW  = 1;
  localparam int CFG_DW  = 8;
  localparam int IN_DW   = 16;
  localparam int IN_UW   = 8;
  localparam int OUT_DW  = 32;
  localparam int OUT_PAD_W = OUT_DW - (1 + PTR_W + 1 + CNT_W + NCNT_W + 1);

  localparam logic [MAXN_W-1:0] MAX_NEW_RST  = MAXN_W'(50);
  localparam logic [MAXL_W-1:0] MAX_LOOP_RST = MAXL_W'(100);

  typedef enum logic [REQ_W-1:0] {
    REQ_RECORD = 3'd0,
    REQ_LOOP   = 3'd1,
    REQ_CLEAR  = 3'd2,
    REQ_NEXT   = 3'd3,
    REQ_QUERY  = 3'd4
  } req_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_MAX_NEW  = 1'b0,
    CFG_MAX_LOOP = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MRG_RD = 4'b0010,
    ST_MRG_WR = 4'b0100,
    ST_RESP   = 4'b1000
  } state_t;

  typedef struct packed {
    logic accept;   // item taken this cycle
    logic merging;  // merge walk owns the loop read port
    logic wr;       // write one merged entry
    logic load;     // load result register
  } lhrm_cmd_t;

  typedef struct packed {
    logic start_merge; // pending item is a loop reset with new hits held
    logic last;        // current merge write is the final one
  } lhrm_status_t;

endpackage

// ===== hdl/lhrm_ctrl.sv =====
// ---------------------------------------------------------------------------
// lhrm_ctrl
// Sequencer: item intake, merge walk and result hand-off.
// ---------------------------------------------------------------------------
module lhrm_ctrl import lhrm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  lhrm_status_t status,
  output lhrm_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd.accept  = 1'b0;
    cmd.merging = 1'b0;
    cmd.wr      = 1'b0;
    cmd.load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = status.start_merge ? ST_MRG_RD : ST_RESP;
        end
      end
      ST_MRG_RD: begin
        cmd.merging = 1'b1;
        state_nxt   = ST_MRG_WR;
      end
      ST_MRG_WR: begin
        cmd.merging = 1'b1;
        cmd.wr      = 1'b1;
        state_nxt   = status.last ? ST_RESP : ST_MRG_RD;
      end
      ST_RESP: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.load)   out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/lhrm_dpath.sv =====
// ---------------------------------------------------------------------------
// lhrm_dpath
// Hit lists, playback pointer, merge datapath and result register.
// ---------------------------------------------------------------------------
module lhrm_dpath import lhrm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  lhrm_cmd_t           cmd,
  output lhrm_status_t        status,
  input  logic [REQ_W-1:0]    in_req,
  input  logic [POS_BITS-1:0] in_ratio,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_data,
  output logic [OUT_DW-1:0]   out_data
);

  // two loop banks: the live list sits in bank sel_r, merges fill the other
  logic [POS_BITS-1:0] bank0 [LOOP_DEPTH];
  logic [POS_BITS-1:0] bank1 [LOOP_DEPTH];
  logic [POS_BITS-1:0] new_mem [NEW_DEPTH];
  logic [POS_BITS-1:0] rd0_q, rd1_q, rdn_q;

  logic [MAXN_W-1:0]   max_new_r, max_new_nxt;
  logic [MAXL_W-1:0]   max_loop_r, max_loop_nxt;
  logic [LEN_W-1:0]    loop_len_r, loop_len_nxt;
  logic [NLEN_W-1:0]   new_len_r, new_len_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  logic                active_r, active_nxt;
  logic                sel_r, sel_nxt;
  logic [LEN_W-1:0]    a_r, a_nxt;
  logic [NLEN_W-1:0]   b_r, b_nxt;
  logic [LEN_W-1:0]    k_r, k_nxt;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic                repl_r, repl_nxt;
  logic                qok_r, qok_nxt;
  logic [POS_BITS-1:0] ratio_r;
  logic [OUT_DW-1:0]   out_data_r;

  logic [LOOP_AW-1:0]  rd_addr;
  logic [POS_BITS-1:0] loop_rd, wr_val;
  logic                take_loop, rec_ok, over, wr0, wr1, has_hit;
  logic [TOT_W-1:0]    total;
  logic [LEN_W-1:0]    repl_cnt;

  assign rd_addr = cmd.merging ? a_r[LOOP_AW-1:0] : ptr_r[LOOP_AW-1:0];
  assign loop_rd = sel_r ? rd1_q : rd0_q;
  assign wr0     = cmd.wr && sel_r;
  assign wr1     = cmd.wr && !sel_r;

  // loop entries win ties; replace mode takes only new entries
  assign take_loop = !repl_r && (a_r < loop_len_r) &&
                     ((b_r >= new_len_r) || !(rdn_q < loop_rd));
  assign wr_val    = take_loop ? loop_rd : rdn_q;

  assign total    = TOT_W'(loop_len_r) + TOT_W'(new_len_r);
  assign over     = (total > TOT_W'(max_loop_r)) || (total > TOT_W'(LOOP_DEPTH));
  assign repl_cnt = (LEN_W'(new_len_r) < LEN_W'(LOOP_DEPTH)) ?
                    LEN_W'(new_len_r) : LEN_W'(LOOP_DEPTH);
  assign rec_ok   = (in_req == REQ_RECORD) && (new_len_r < max_new_r) &&
                    (new_len_r < NLEN_W'(NEW_DEPTH));

  assign status.start_merge = (in_req == REQ_LOOP) && (new_len_r != '0);
  assign status.last        = (k_r == cnt_r - LEN_W'(1));

  assign has_hit  = qok_r && (loop_rd < ratio_r);
  assign out_data = out_data_r;

  always_ff @(posedge clk) begin
    if (wr0) bank0[k_r[LOOP_AW-1:0]] <= wr_val;
    rd0_q <= bank0[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr1) bank1[k_r[LOOP_AW-1:0]] <= wr_val;
    rd1_q <= bank1[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && rec_ok) new_mem[new_len_r[NEW_AW-1:0]] <= in_ratio;
    rdn_q <= new_mem[b_r[NEW_AW-1:0]];
  end

  always_comb begin
    max_new_nxt  = max_new_r;
    max_loop_nxt = max_loop_r;
    loop_len_nxt = loop_len_r;
    new_len_nxt  = new_len_r;
    ptr_nxt      = ptr_r;
    active_nxt   = active_r;
    sel_nxt      = sel_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    k_nxt        = k_r;
    cnt_nxt      = cnt_r;
    repl_nxt     = repl_r;
    qok_nxt      = qok_r;

    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_MAX_NEW:  max_new_nxt  = cfg_data[MAXN_W-1:0];
        CFG_MAX_LOOP: max_loop_nxt = cfg_data[MAXL_W-1:0];
        default: ;
      endcase
    end

    if (cmd.accept) begin
      repl_nxt = 1'b0;
      qok_nxt  = 1'b0;
      a_nxt    = '0;
      b_nxt    = '0;
      k_nxt    = '0;
      unique case (in_req)
        REQ_RECORD: begin
          if (rec_ok) new_len_nxt = new_len_r + NLEN_W'(1);
        end
        REQ_LOOP: begin
          ptr_nxt    = '0;
          active_nxt = 1'b1;
          repl_nxt   = status.start_merge && over;
          cnt_nxt    = over ? repl_cnt : LEN_W'(total);
        end
        REQ_CLEAR: begin
          loop_len_nxt = '0;
          new_len_nxt  = '0;
        end
        REQ_NEXT: begin
          if (!active_r || (LEN_W'(ptr_r) + LEN_W'(1) >= loop_len_r)) begin
            active_nxt = 1'b0;
            ptr_nxt    = '0;
          end else begin
            ptr_nxt = ptr_r + PTR_W'(1);
          end
        end
        REQ_QUERY: qok_nxt = active_r && (LEN_W'(ptr_r) < loop_len_r);
        default: ;
      endcase
    end

    if (cmd.wr) begin
      k_nxt = k_r + LEN_W'(1);
      if (take_loop) a_nxt = a_r + LEN_W'(1);
      else           b_nxt = b_r + NLEN_W'(1);
      if (status.last) begin
        sel_nxt      = !sel_r;
        loop_len_nxt = cnt_r;
        new_len_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_new_r  <= MAX_NEW_RST;
      max_loop_r <= MAX_LOOP_RST;
      loop_len_r <= '0;
      new_len_r  <= '0;
      ptr_r      <= '0;
      active_r   <= 1'b1;
      sel_r      <= 1'b0;
      a_r        <= '0;
      b_r        <= '0;
      k_r        <= '0;
      cnt_r      <= '0;
      repl_r     <= 1'b0;
      qok_r      <= 1'b0;
    end else begin
      max_new_r  <= max_new_nxt;
      max_loop_r <= max_loop_nxt;
      loop_len_r <= loop_len_nxt;
      new_len_r  <= new_len_nxt;
      ptr_r      <= ptr_nxt;
      active_r   <= active_nxt;
      sel_r      <= sel_nxt;
      a_r        <= a_nxt;
      b_r        <= b_nxt;
      k_r        <= k_nxt;
      cnt_r      <= cnt_nxt;
      repl_r     <= repl_nxt;
      qok_r      <= qok_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) ratio_r <= in_ratio;
    if (cmd.load) begin
      out_data_r <= {OUT_PAD_W'(0), repl_r, NCNT_W'(new_len_r), CNT_W'(loop_len_r),
                     active_r, (active_r ? ptr_r : PTR_W'(0)), has_hit};
    end
  end

endmodule

// ===== hdl/loop_hit_recorder_merge_unit.sv =====
// ---------------------------------------------------------------------------
// loop_hit_recorder_merge_unit
// Looper hit store: sorted loop list, new hit list and playback pointer.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one request item per handshake. in_tuser carries the request
//           kind, in_tdata the Q0.16 loop position.
//   out_* : exactly one result item per request, in request order.
//   cfg_* : register writes (0 max_new_hits, 1 max_loop_hits); always ready,
//           write only while the block is idle.
// Sequence:
//   Record, loop reset with no new hits, clear, next and query: the item is
//   taken in idle and its result is loaded in the response state once the
//   output register is free; no next item is taken before that load.
//   Loop reset with new hits: the merge walk writes N entries, N = merged
//   length, or the new list length on replace. Each entry takes a read state
//   and a write state through the registered memory ports.
// Reset (rst_n low, synchronous): lists empty, pointer 0 and active,
//   registers back to 50 and 100. Memory contents are not cleared; only
//   entries below the current lengths are ever used, so no clearing pass.
// Stall: a result waits in the output register while out_tready is low;
//   the next item's result waits, with in_tready low, until it drains.
// ---------------------------------------------------------------------------
module loop_hit_recorder_merge_unit import lhrm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [15:0] ratio
  input  logic [IN_UW-1:0]  in_tuser,   // [2:0] req_type, [7:3] zero
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [0] has_hit, [7:1] hit_index,
                                        // [8] index_active, [16:9] loop_count,
                                        // [23:17] new_count, [24] replaced,
                                        // [31:25] zero
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data
);

  lhrm_cmd_t    cmd;
  lhrm_status_t status;

  // config is always taken; software must write only while idle (not enforced here)
  assign cfg_ready = 1'b1;

  // sequencer: intake, merge walk, result hand-off
  lhrm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // lists, pointer and result register
  lhrm_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_req   (in_tuser[REQ_W-1:0]),
    .in_ratio (in_tdata[POS_BITS-1:0]),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .out_data (out_tdata)
  );

endmodule

// ===== hdl/lhrm_checker.sv =====
// ---------------------------------------------------------------------------
// lhrm_checker
// Port-level checks for the loop hit recorder merge unit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lhrm_checker import lhrm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata
);

  // stalled result holds
  `CHK_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)))

  // in_tready drops in the cycle after an item is taken
  `CHK_ASSERT(a_in_gap, clk, rst_n, (in_tvalid && in_tready |=> !in_tready))

  // a hit is only reported against an active pointer
  `CHK_ASSERT(a_hit_active, clk, rst_n, (out_tvalid && out_tdata[0] |-> out_tdata[8]))

  // no result survives reset
  `CHK_ASSERT_NR(a_rst_empty, clk, (!rst_n |=> !out_tvalid))

endmodule

bind loop_hit_recorder_merge_unit lhrm_checker u_lhrm_checker (.*);
